FILE: rtl/sha512_hash_core_macros.svh
// Assertion macros for the SHA-512 hash core
`ifndef SHA512_HASH_CORE_MACROS_SVH
`define SHA512_HASH_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(label, clk, rst_n, prop, msg)
`define SHA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/sha512_pkg.sv
// Types, constants and round functions for the SHA-512 hash core
package sha512_pkg;
	localparam int unsigned NumRounds = 80;
	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [6:0] PadLimit = 7'd112;
	localparam logic [6:0] LenPos = 7'd120;

	typedef logic [63:0] word_t;

	typedef enum logic [0:0] {
		KIND_BYTE = 1'b0,
		KIND_FINISH = 1'b1
	} kind_t;

	typedef struct packed {
		logic [0:0] kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0] word_index;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic init;
		logic round;
		logic fold;
		logic [6:0] rnd;
	} rnd_ctl_t;

	function automatic word_t iv(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = 64'h6a09e667f3bcc908;
			3'd1: r = 64'hbb67ae8584caa73b;
			3'd2: r = 64'h3c6ef372fe94f82b;
			3'd3: r = 64'ha54ff53a5f1d36f1;
			3'd4: r = 64'h510e527fade682d1;
			3'd5: r = 64'h9b05688c2b3e6c1f;
			3'd6: r = 64'h1f83d9abfb41bd6b;
			default: r = 64'h5be0cd19137e2179;
		endcase
		return r;
	endfunction

	localparam word_t RoundConst [NumRounds] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction
endpackage

FILE: rtl/sha512_stream_if.sv
// Valid/ready channel interfaces for the SHA-512 hash core
interface sha512_in_if import sha512_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sha512_out_if import sha512_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sha512_sched.sv
// Rolling sixteen-word message buffer and schedule expansion
module sha512_sched import sha512_pkg::*; (
	input logic clk,
	input logic wr_byte,
	input logic [6:0] wr_pos,
	input logic [7:0] wr_val,
	input logic wr_len,
	input word_t len_bits,
	input rnd_ctl_t ctl,
	output word_t w_out
);
	word_t w_q [16];
	word_t s0, s1, w_new;
	logic [3:0] idx;
	logic [5:0] sh;

	assign idx = wr_pos[6:3];
	assign sh = 6'd56 - {wr_pos[2:0], 3'b000};
	assign s0 = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
	assign s1 = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
	assign w_new = w_q[0] + s0 + w_q[9] + s1;
	assign w_out = w_q[0];

	always_ff @(posedge clk) begin
		if (ctl.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end else begin
			if (wr_byte) begin
				w_q[idx] <= (w_q[idx] & ~(64'hFF << sh)) | (word_t'(wr_val) << sh);
			end
			if (wr_len) begin
				w_q[15] <= len_bits;
			end
		end
	end
endmodule

FILE: rtl/sha512_round.sv
// Shared round unit with working variables and chain value
module sha512_round import sha512_pkg::*; (
	input logic clk,
	input logic arst_n,
	input rnd_ctl_t ctl,
	input logic reset_chain,
	input word_t w_in,
	input logic [2:0] rd_idx,
	output word_t chain_word
);
	word_t h_q [8];
	word_t v_q [8];
	word_t t1, t2, k;

	assign k = RoundConst[ctl.rnd];
	assign t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + k + w_in;
	assign t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign chain_word = h_q[rd_idx];

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (ctl.round) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= iv(3'(i));
		end else if (reset_chain) begin
			for (int i = 0; i < 8; i++) h_q[i] <= iv(3'(i));
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end
endmodule

FILE: rtl/sha512_hash_core.sv
// SHA-512 hash core top level: byte intake, padding and round sequencer
// Usage:
//   in channel carries kind and data_byte. kind 0 adds one message byte,
//   kind 1 finishes the message and yields eight digest words on out.
//   out carries digest_word, word_index and last (set on word 7).
// Timing:
//   The 128th byte of a block starts a compression (load, 80 rounds,
//   fold) in the shared round unit, during which in is not ready. A
//   finish pads one byte per cycle, runs one or two compressions and then
//   presents the eight words, one per cycle while the receiver takes them.
//   Sustained byte rate is set by the single round unit.
// Reset:
//   arst_n clears the sequencer, fill and byte count and loads the initial
//   hash values. The message buffer is not cleared.
// Stall:
//   While the receiver holds out.ready low the current word is held and no
//   input is taken until the last word transfers.
`include "sha512_hash_core_macros.svh"
module sha512_hash_core import sha512_pkg::*; (
	input logic clk,
	input logic arst_n,
	sha512_in_if.sink in_ch,
	sha512_out_if.source out_ch
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PAD = 6'b000010,
		ST_INIT = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_FOLD = 6'b010000,
		ST_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [6:0] fill_q, rnd_q;
	logic [60:0] total_q;
	logic fin_q, len_done_q, ovf_q;
	logic [2:0] oidx_q;
	logic acc, pad_last;
	logic wr_byte, wr_len;
	logic [7:0] wr_val;
	rnd_ctl_t ctl;
	word_t w, cw;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.data.digest_word = cw;
	assign out_ch.data.word_index = oidx_q;
	assign out_ch.data.last = (oidx_q == 3'd7);

	// pad run ends at the block end (overflow) or at the length word
	assign pad_last = (fill_q == 7'd127)
		|| (!ovf_q && !len_done_q && fill_q == LenPos - 7'd1);
	assign wr_byte = (acc && in_ch.data.kind == KIND_BYTE)
		|| (acc && in_ch.data.kind == KIND_FINISH) || (state_q == ST_PAD);
	assign wr_val = (state_q == ST_PAD) ? 8'h00
		: (in_ch.data.kind == KIND_FINISH) ? PadByte : in_ch.data.data_byte;
	assign wr_len = (state_q == ST_PAD) && !ovf_q && !len_done_q
		&& fill_q == LenPos - 7'd1;

	assign ctl.init = (state_q == ST_INIT);
	assign ctl.round = (state_q == ST_ROUND);
	assign ctl.fold = (state_q == ST_FOLD);
	assign ctl.rnd = rnd_q;

	sha512_sched u_sched (
		.clk(clk), .wr_byte(wr_byte), .wr_pos(fill_q), .wr_val(wr_val),
		.wr_len(wr_len), .len_bits({total_q, 3'b000}), .ctl(ctl), .w_out(w)
	);

	sha512_round u_round (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.reset_chain(out_ch.valid && out_ch.ready && oidx_q == 3'd7),
		.w_in(w), .rd_idx(oidx_q), .chain_word(cw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			rnd_q <= '0;
			total_q <= '0;
			fin_q <= 1'b0;
			len_done_q <= 1'b0;
			ovf_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						fill_q <= fill_q + 7'd1;
						if (in_ch.data.kind == KIND_BYTE) begin
							total_q <= total_q + 61'd1;
							fin_q <= 1'b0;
							if (fill_q == 7'd127) state_q <= ST_INIT;
						end else begin
							fin_q <= 1'b1;
							len_done_q <= 1'b0;
							ovf_q <= (fill_q >= PadLimit);
							if (fill_q == 7'd127 || fill_q == LenPos - 7'd1) begin
								state_q <= (fill_q == 7'd127) ? ST_INIT : ST_PAD;
							end else begin
								state_q <= ST_PAD;
							end
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 7'd1;
					if (pad_last) begin
						if (wr_len) len_done_q <= 1'b1;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(NumRounds - 1)) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					fill_q <= '0;
					ovf_q <= 1'b0;
					if (!fin_q) state_q <= ST_IDLE;
					else if (len_done_q) begin
						oidx_q <= '0;
						state_q <= ST_OUT;
					end else state_q <= ST_PAD;
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_IDLE;
							total_q <= '0;
							fin_q <= 1'b0;
							len_done_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SHA_ASSERT(a_no_in_busy, clk, arst_n, (state_q != ST_IDLE) |-> !in_ch.ready, "input taken while busy")
	`SHA_ASSERT(a_round_cnt, clk, arst_n, (state_q == ST_FOLD) |-> ($past(rnd_q) == 7'(NumRounds - 1)), "fold before round 79")
	`SHA_ASSERT(a_out_hold, clk, arst_n, (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(oidx_q)), "word dropped under stall")
	`SHA_ASSERT(a_out_fin, clk, arst_n, out_ch.valid |-> (fin_q && len_done_q), "digest without finish")
endmodule
